[rtl/core/keyword_substitution_cipher_core_macros.svh]
// assertion macros for the keyword substitution cipher core
`ifndef KEYWORD_SUBSTITUTION_CIPHER_CORE_MACROS_SVH
`define KEYWORD_SUBSTITUTION_CIPHER_CORE_MACROS_SVH

// same-cycle implication, clocked on clk, off during rst
`define KWSC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("kwsc assertion failed");

// next-cycle implication, clocked on clk, off during rst
`define KWSC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("kwsc assertion failed");

`endif

[rtl/core/kwsc_pkg.sv]
// shared types and constants of the keyword substitution cipher core
package kwsc_pkg;

  localparam int ALPHABET_SIZE_DEF = 26;
  localparam int ENTRY_W = 5;
  localparam int CMD_W = 3;
  localparam int CHAR_W = 8;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR   = 3'd0,
    CMD_KEY     = 3'd1,
    CMD_FINISH  = 3'd2,
    CMD_ENCRYPT = 3'd3,
    CMD_DECRYPT = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FILL,
    ST_INV
  } state_t;

  localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;
  localparam logic [CHAR_W-1:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_A = 8'h61;
  localparam logic [CHAR_W-1:0] CHAR_LOWER_Z = 8'h7A;
  localparam logic [CHAR_W-1:0] CHAR_NONE    = 8'h00;

  typedef struct packed {
    logic               we;
    logic [ENTRY_W-1:0] waddr;
    logic [ENTRY_W-1:0] wdata;
    logic               re;
    logic [ENTRY_W-1:0] raddr;
  } tbl_req_t;

endpackage

[rtl/core/kwsc_if.sv]
// valid/ready channel interfaces for the cipher input items and results
interface kwsc_in_if;
  logic                          valid;
  logic                          ready;
  logic [kwsc_pkg::CMD_W-1:0]    command;
  logic [kwsc_pkg::CHAR_W-1:0]   char_in;

  modport source (output valid, output command, output char_in, input ready);
  modport sink (input valid, input command, input char_in, output ready);
endinterface

interface kwsc_out_if;
  logic                          valid;
  logic                          ready;
  logic [kwsc_pkg::CHAR_W-1:0]   char_out;

  modport source (output valid, output char_out, input ready);
  modport sink (input valid, input char_out, output ready);
endinterface

[rtl/core/kwsc_table.sv]
// substitution table: synchronous memory, one write and one read port, identity until written
module kwsc_table #(
  parameter int DEPTH = kwsc_pkg::ALPHABET_SIZE_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  kwsc_pkg::tbl_req_t           req,
  output logic [kwsc_pkg::ENTRY_W-1:0] rdata
);
  import kwsc_pkg::*;

  localparam int IDX_W = $clog2(DEPTH);

  logic [ENTRY_W-1:0] mem [DEPTH];
  logic [DEPTH-1:0]   written;
  logic [ENTRY_W-1:0] mem_q;
  logic               written_q;
  logic [IDX_W-1:0]   raddr_q;
  logic [IDX_W-1:0]   widx;
  logic [IDX_W-1:0]   ridx;

  assign widx = req.waddr[IDX_W-1:0];
  assign ridx = req.raddr[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[widx] <= req.wdata;
    end
    if (req.re) begin
      mem_q     <= mem[ridx];
      written_q <= written[ridx];
      raddr_q   <= ridx;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (req.we) begin
      written[widx] <= 1'b1;
    end
  end

  // entries never written read as identity
  assign rdata = written_q ? mem_q : ENTRY_W'(raddr_q);

endmodule

[rtl/core/keyword_substitution_cipher_core.sv]
// Keyword substitution cipher core. Clear, key-character, encrypt and decrypt items are
// taken one per cycle unless a held result stalls the input; an encrypt or decrypt result
// reaches the result channel through the table's read register and then an output register,
// so lookups stream at one per cycle while results are taken. A finish item walks the tables:
// it fills the forward table with the unused letters, then reads it back and writes the inverse
// table, and no item is taken until the walk is done. Both tables are single-read-port
// synchronous memories and read as identity until written.
module keyword_substitution_cipher_core #(
  parameter int ALPHABET_SIZE = kwsc_pkg::ALPHABET_SIZE_DEF
) (
  input logic        clk,
  input logic        rst,
  kwsc_in_if.sink    item,
  kwsc_out_if.source result
);
  import kwsc_pkg::*;

  localparam int IDX_W = $clog2(ALPHABET_SIZE);
  localparam int CNT_W = $clog2(ALPHABET_SIZE + 1);
  localparam logic [CNT_W-1:0]   LAST       = CNT_W'(ALPHABET_SIZE - 1);
  localparam logic [CNT_W-1:0]   FULL       = CNT_W'(ALPHABET_SIZE);
  localparam logic [CHAR_W-1:0]  SIZE_CHAR  = CHAR_W'(ALPHABET_SIZE);
  localparam logic [ENTRY_W:0]   SIZE_ENTRY = (ENTRY_W + 1)'(ALPHABET_SIZE);

  state_t                 state;
  state_t                 state_next;
  logic [ALPHABET_SIZE-1:0] letter_used;
  logic [CNT_W-1:0]       key_length;
  logic [CNT_W-1:0]       sweep_j;
  logic [CNT_W-1:0]       sweep_pos;
  logic [CNT_W-1:0]       inv_i;
  logic [IDX_W-1:0]       inv_i_q;
  logic                   inv_rd_pend;
  logic                   pend;
  logic                   pend_letter;
  logic                   pend_dec;
  logic                   out_valid;
  logic [CHAR_W-1:0]      char_q;

  cmd_t                   cmd;
  logic                   transfer;
  logic                   is_upper;
  logic                   is_lower;
  logic [CHAR_W-1:0]      ch_off;
  logic                   is_letter;
  logic [ENTRY_W-1:0]     letter;
  logic [IDX_W-1:0]       letter_i;
  logic                   key_take;
  logic                   fill_take;
  logic                   inv_take;
  logic                   lookup_take;
  logic                   pend_move;
  logic [ENTRY_W-1:0]     pend_val;

  tbl_req_t               fwd_req;
  tbl_req_t               inv_req;
  logic [ENTRY_W-1:0]     fwd_rdata;
  logic [ENTRY_W-1:0]     inv_rdata;

  kwsc_table #(.DEPTH(ALPHABET_SIZE)) u_fwd (
    .clk   (clk),
    .rst   (rst),
    .req   (fwd_req),
    .rdata (fwd_rdata)
  );

  kwsc_table #(.DEPTH(ALPHABET_SIZE)) u_inv (
    .clk   (clk),
    .rst   (rst),
    .req   (inv_req),
    .rdata (inv_rdata)
  );

  // character decode
  always_comb begin
    cmd       = cmd_t'(item.command);
    transfer  = item.valid && item.ready;
    is_upper  = (item.char_in >= CHAR_UPPER_A) && (item.char_in <= CHAR_UPPER_Z);
    is_lower  = (item.char_in >= CHAR_LOWER_A) && (item.char_in <= CHAR_LOWER_Z);
    ch_off    = is_upper ? (item.char_in - CHAR_UPPER_A) : (item.char_in - CHAR_LOWER_A);
    is_letter = (is_upper || is_lower) && (ch_off < SIZE_CHAR);
    letter    = ch_off[ENTRY_W-1:0];
    letter_i  = ch_off[IDX_W-1:0];
  end

  assign key_take    = transfer && (cmd == CMD_KEY) && is_letter && !letter_used[letter_i]
                       && (key_length < FULL);
  assign fill_take   = (state == ST_FILL) && !letter_used[sweep_j[IDX_W-1:0]]
                       && (sweep_pos < FULL);
  assign inv_take    = inv_rd_pend && ({1'b0, fwd_rdata} < SIZE_ENTRY);
  assign lookup_take = transfer && ((cmd == CMD_ENCRYPT) || (cmd == CMD_DECRYPT));
  assign pend_move   = pend && (!out_valid || result.ready);
  assign pend_val    = pend_dec ? inv_rdata : fwd_rdata;

  always_comb begin
    fwd_req = '0;
    if (key_take) begin
      fwd_req.we    = 1'b1;
      fwd_req.waddr = ENTRY_W'(key_length);
      fwd_req.wdata = letter;
    end else if (fill_take) begin
      fwd_req.we    = 1'b1;
      fwd_req.waddr = ENTRY_W'(sweep_pos);
      fwd_req.wdata = ENTRY_W'(sweep_j);
    end
    if (transfer && (cmd == CMD_ENCRYPT) && is_letter) begin
      fwd_req.re    = 1'b1;
      fwd_req.raddr = letter;
    end else if ((state == ST_INV) && (inv_i != FULL)) begin
      fwd_req.re    = 1'b1;
      fwd_req.raddr = ENTRY_W'(inv_i);
    end
  end

  always_comb begin
    inv_req       = '0;
    inv_req.we    = inv_take;
    inv_req.waddr = fwd_rdata;
    inv_req.wdata = ENTRY_W'(inv_i_q);
    inv_req.re    = transfer && (cmd == CMD_DECRYPT) && is_letter;
    inv_req.raddr = letter;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    item.ready = (state == ST_IDLE) && (!pend || pend_move);
    case (state)
      ST_IDLE: begin
        if (transfer && (cmd == CMD_FINISH)) begin
          state_next = ST_FILL;
        end
      end
      ST_FILL: begin
        if (sweep_j == LAST) begin
          state_next = ST_INV;
        end
      end
      ST_INV: begin
        if (inv_i == FULL) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // key state
  always_ff @(posedge clk) begin
    if (rst) begin
      letter_used <= '0;
      key_length  <= '0;
    end else if (transfer && (cmd == CMD_CLEAR)) begin
      letter_used <= '0;
      key_length  <= '0;
    end else if (key_take) begin
      letter_used[letter_i] <= 1'b1;
      key_length            <= key_length + 1'b1;
    end
  end

  // finish sweep counters
  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_j     <= '0;
      sweep_pos   <= '0;
      inv_i       <= '0;
      inv_rd_pend <= 1'b0;
    end else begin
      inv_rd_pend <= (state == ST_INV) && (inv_i != FULL);
      if (transfer && (cmd == CMD_FINISH)) begin
        sweep_j   <= '0;
        sweep_pos <= key_length;
        inv_i     <= '0;
      end else if (state == ST_FILL) begin
        sweep_j <= sweep_j + 1'b1;
        if (fill_take) begin
          sweep_pos <= sweep_pos + 1'b1;
        end
      end else if ((state == ST_INV) && (inv_i != FULL)) begin
        inv_i <= inv_i + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    inv_i_q <= inv_i[IDX_W-1:0];
  end

  // lookup in flight and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      pend      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (lookup_take) begin
        pend <= 1'b1;
      end else if (pend_move) begin
        pend <= 1'b0;
      end
      if (pend_move) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (lookup_take) begin
      pend_letter <= is_letter;
      pend_dec    <= (cmd == CMD_DECRYPT);
    end
    if (pend_move) begin
      char_q <= pend_letter ? (CHAR_LOWER_A + CHAR_W'(pend_val)) : CHAR_NONE;
    end
  end

  assign result.valid    = out_valid;
  assign result.char_out = char_q;

endmodule

[rtl/core/kwsc_checker.sv]
// port-level checker for the cipher core, bound to the top level
`include "keyword_substitution_cipher_core_macros.svh"

module kwsc_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic [kwsc_pkg::CMD_W-1:0]  command,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [kwsc_pkg::CHAR_W-1:0] char_out
);
  import kwsc_pkg::*;

  logic in_xfer;
  logic finish_xfer;
  logic lookup_xfer;
  logic key_xfer;
  logic out_legal;

  assign in_xfer     = in_valid && in_ready;
  assign finish_xfer = in_xfer && (command == CMD_FINISH);
  assign lookup_xfer = in_xfer && ((command == CMD_ENCRYPT) || (command == CMD_DECRYPT));
  assign key_xfer    = in_xfer && (command == CMD_KEY);
  assign out_legal   = (char_out == CHAR_NONE)
                       || ((char_out >= CHAR_LOWER_A) && (char_out <= (CHAR_LOWER_A + 8'd31)));

  // stalled result holds
  `KWSC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(char_out))

  // results are zero or a letter code
  `KWSC_ASSERT_NOW(a_out_range, out_valid, out_legal)

  // table rebuild blocks the input channel
  `KWSC_ASSERT_NEXT(a_finish_busy, finish_xfer, !in_ready)

  // key commands never produce a result by themselves
  `KWSC_ASSERT_NEXT(a_key_quiet, key_xfer && !out_valid && !$past(lookup_xfer), !out_valid)

endmodule

bind keyword_substitution_cipher_core kwsc_checker u_kwsc_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (item.valid),
  .in_ready  (item.ready),
  .command   (item.command),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .char_out  (result.char_out)
);
